// ===== hdl/yuv420_pixel_pair_to_rgba_unit_macros.svh =====
// Assertion helpers shared by the pixel pair converter.
`ifndef YUV420_PIXEL_PAIR_TO_RGBA_UNIT_MACROS_SVH
`define YUV420_PIXEL_PAIR_TO_RGBA_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define YUVRGBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("yuvrgba assertion failed");

// Next-cycle implication, disabled during reset.
`define YUVRGBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("yuvrgba assertion failed");

`endif

// ===== hdl/yuvrgba_pkg.sv =====
`default_nettype none

package yuvrgba_pkg;

  // Signed width of a single product term and of a channel sum
  localparam int PartW = 16;
  localparam int SumW  = 17;

  // Quotient by 64 is a shift; sums at or above 256*64 saturate
  localparam int FracBits = 6;
  localparam int ChanW    = 8;

  localparam logic [ChanW-1:0]       LumaOffset   = 8'd16;
  localparam logic [ChanW-1:0]       ChromaOffset = 8'd128;
  localparam logic signed [PartW-1:0] LumaGain    = 16'sd75;
  localparam logic signed [PartW-1:0] CrToR       = 16'sd102;
  localparam logic signed [PartW-1:0] CbToG       = -16'sd25;
  localparam logic signed [PartW-1:0] CrToG       = -16'sd52;
  localparam logic signed [PartW-1:0] CbToB       = 16'sd128;
  localparam logic [ChanW-1:0]       ChanMax      = 8'd255;
  localparam logic [ChanW-1:0]       AlphaReset   = 8'd255;

  typedef struct packed {
    logic [7:0] luma_left;
    logic [7:0] luma_right;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
  } pair_in_t;

  typedef struct packed {
    logic [7:0] red_left;
    logic [7:0] green_left;
    logic [7:0] blue_left;
    logic [7:0] alpha_left;
    logic [7:0] red_right;
    logic [7:0] green_right;
    logic [7:0] blue_right;
    logic [7:0] alpha_right;
  } pair_out_t;

  // Chroma contributions shared by both lanes
  typedef struct packed {
    logic signed [PartW-1:0] r_part;
    logic signed [PartW-1:0] g_part;
    logic signed [PartW-1:0] b_part;
  } chroma_parts_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // Truncating divide by 64 and clamp to 0..255
  function automatic logic [ChanW-1:0] clamp_channel(logic signed [SumW-1:0] s);
    logic [ChanW-1:0] res;
    if (s[SumW-1]) begin
      res = '0;
    end else if (|s[SumW-2:ChanW+FracBits]) begin
      res = ChanMax;
    end else begin
      res = s[ChanW+FracBits-1:FracBits];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/yuvrgba_chroma.sv =====
`default_nettype none

module yuvrgba_chroma
  import yuvrgba_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic [7:0]    chroma_u_i,
  input  wire logic [7:0]    chroma_v_i,
  output chroma_parts_t      parts_o
);

  logic signed [8:0]       u_off, v_off;
  logic signed [PartW-1:0] u_ext, v_ext;
  chroma_parts_t           parts_d, parts_q;

  // Remove the 128 offset, then apply the constant matrix
  always_comb begin
    u_off = $signed({1'b0, chroma_u_i}) - $signed({1'b0, ChromaOffset});
    v_off = $signed({1'b0, chroma_v_i}) - $signed({1'b0, ChromaOffset});
    u_ext = PartW'(u_off);
    v_ext = PartW'(v_off);
    parts_d.r_part = v_ext * CrToR;
    parts_d.g_part = u_ext * CbToG + v_ext * CrToG;
    parts_d.b_part = u_ext * CbToB;
  end

  always_ff @(posedge clk_i) begin
    parts_q <= parts_d;
  end

  assign parts_o = parts_q;

endmodule

`default_nettype wire

// ===== hdl/yuvrgba_lane.sv =====
`default_nettype none

module yuvrgba_lane
  import yuvrgba_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic [7:0]    luma_i,
  input  wire chroma_parts_t parts_i,
  output rgb_t               rgb_o
);

  logic signed [8:0]       y_off;
  logic signed [PartW-1:0] y_term_d, y_term_q;
  logic signed [SumW-1:0]  y_sum, r_sum, g_sum, b_sum;
  rgb_t                    rgb_d, rgb_q;

  // Stage 1: luma term 75*(Y-16)
  always_comb begin
    y_off    = $signed({1'b0, luma_i}) - $signed({1'b0, LumaOffset});
    y_term_d = PartW'(y_off) * LumaGain;
  end

  always_ff @(posedge clk_i) begin
    y_term_q <= y_term_d;
  end

  // Stage 2: add chroma parts, scale and clamp each channel
  always_comb begin
    y_sum       = SumW'(y_term_q);
    r_sum       = y_sum + SumW'(parts_i.r_part);
    g_sum       = y_sum + SumW'(parts_i.g_part);
    b_sum       = y_sum + SumW'(parts_i.b_part);
    rgb_d.red   = clamp_channel(r_sum);
    rgb_d.green = clamp_channel(g_sum);
    rgb_d.blue  = clamp_channel(b_sum);
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign rgb_o = rgb_q;

endmodule

`default_nettype wire

// ===== hdl/yuv420_pixel_pair_to_rgba_unit.sv =====
// 4:2:0 pixel pair to RGBA converter (limited-range BT.601, 6-bit fixed point).
//
// Input: in_data_i carries two adjacent luma samples and their shared U/V.
// A transaction is taken on a rising edge with start high and busy low;
// busy stays low, so a new pair can enter on every clock.
// Output: res_data_o holds both RGBA pixels and is valid for exactly one
// cycle while res_valid_o is high. The receiver cannot stall the block.
// An accepted pair passes the stage 1 and stage 2 registers before the result
// strobe; throughput is one pair per clock. Two lanes (one per pixel, two
// registers deep) are fed by one shared chroma multiply stage (one register
// deep) that lines up with the second lane stage.
// Alpha comes from the configuration channel (cfg_valid_i / cfg_ready_o /
// cfg_data_i); cfg_ready_o is always high. Write it only while no pair is
// in flight.
// Reset (rst_ni low, asynchronous) clears the pipeline valid bits and sets
// alpha to 255; no results are produced until a new pair is accepted.
`default_nettype none

module yuv420_pixel_pair_to_rgba_unit
  import yuvrgba_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output      logic       busy,
  input  wire pair_in_t   in_data_i,
  output      logic       res_valid_o,
  output pair_out_t       res_data_o,
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

`include "yuv420_pixel_pair_to_rgba_unit_macros.svh"

  logic          accept;
  logic          v1_q, v2_q;
  logic [7:0]    alpha_q;
  chroma_parts_t parts;
  rgb_t          rgb_left, rgb_right;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Alpha register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      alpha_q <= cfg_data_i;
    end
  end

  // Valid pipeline tracking the two datapath stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  // Shared chroma terms
  yuvrgba_chroma u_chroma (
    .clk_i      (clk_i),
    .chroma_u_i (in_data_i.chroma_u),
    .chroma_v_i (in_data_i.chroma_v),
    .parts_o    (parts)
  );

  // One lane per pixel
  yuvrgba_lane u_lane_left (
    .clk_i   (clk_i),
    .luma_i  (in_data_i.luma_left),
    .parts_i (parts),
    .rgb_o   (rgb_left)
  );

  yuvrgba_lane u_lane_right (
    .clk_i   (clk_i),
    .luma_i  (in_data_i.luma_right),
    .parts_i (parts),
    .rgb_o   (rgb_right)
  );

  // Merge lanes and alpha into the result transaction
  always_comb begin
    res_data_o.red_left    = rgb_left.red;
    res_data_o.green_left  = rgb_left.green;
    res_data_o.blue_left   = rgb_left.blue;
    res_data_o.alpha_left  = alpha_q;
    res_data_o.red_right   = rgb_right.red;
    res_data_o.green_right = rgb_right.green;
    res_data_o.blue_right  = rgb_right.blue;
    res_data_o.alpha_right = alpha_q;
  end

  assign res_valid_o = v2_q;

  // Every accepted pair advances, and nothing appears without a source
  `YUVRGBA_ASSERT_NXT(a_accept_to_s1, clk_i, rst_ni, accept, v1_q)
  `YUVRGBA_ASSERT_NXT(a_s1_to_out, clk_i, rst_ni, v1_q, res_valid_o)
  `YUVRGBA_ASSERT_NXT(a_no_spurious, clk_i, rst_ni, !v1_q, !res_valid_o)
  // Equal luma in both lanes must give identical colors
  `YUVRGBA_ASSERT_IMP(a_lanes_match, clk_i, rst_ni,
    res_valid_o && $past(in_data_i.luma_left == in_data_i.luma_right, 2),
    rgb_left == rgb_right)

endmodule

`default_nettype wire
